// ===== rtl/core/rtl_text_run_reorder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Text run reorder unit: assertion macros
// Concurrent assertion helpers used by the run reorder controller.
// ----------------------------------------------------------------------------
`ifndef RTL_TEXT_RUN_REORDER_UNIT_MACROS_SVH
`define RTL_TEXT_RUN_REORDER_UNIT_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define RTRR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define RTRR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`else

`define RTRR_ASSERT_ALWAYS(label, clk, rst, cond)
`define RTRR_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/rtrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text run reorder unit package
// Shared types and constants of the right-to-left run reorder block.
// ----------------------------------------------------------------------------
package rtrr_pkg;

   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_BYTE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LETTER_OFFSET = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] LEAD_BYTE_RESET     = 8'hD7;
   localparam logic [BYTE_W-1:0] LETTER_OFFSET_RESET = 8'd16;

   // ASCII space.
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_TAIL,
      ST_CODE
   } rtrr_state_type;

   // Access strobes from the controller to the run memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } rtrr_mem_ctl_type;

endpackage

// ===== rtl/core/rtrr_run_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run store memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rtrr_run_mem
   import rtrr_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                clock,
   input  rtrr_mem_ctl_type    mem_ctl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [BYTE_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [BYTE_W-1:0]   rd_data
);

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rtrr_ctrl.sv =====
`timescale 1ns / 1ps
`include "rtl_text_run_reorder_unit_macros.svh"
// ----------------------------------------------------------------------------
// Run reorder controller
// Classifies each request byte, pushes run bytes into the run memory and
// drains a run in reverse through the registered result stage.
// ----------------------------------------------------------------------------
module rtrr_ctrl
   import rtrr_pkg::*;
#(
   parameter int RUN_DEPTH = 32,
   parameter int ADDR_W    = 5,
   parameter int CNT_W     = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata,
   // Requests
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_byte,
   input  logic                  req_end,
   // Results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_byte,
   output logic                  rsp_burst_last,
   output logic                  rsp_text_done,
   output logic                  rsp_overflow,
   // Run memory
   output rtrr_mem_ctl_type      mem_ctl,
   output logic [ADDR_W-1:0]     mem_wr_addr,
   output logic [BYTE_W-1:0]     mem_wr_data,
   output logic [ADDR_W-1:0]     mem_rd_addr,
   input  logic [BYTE_W-1:0]     mem_rd_data
);

   // Control registers
   rtrr_state_type    state_ff, state_in;
   logic [BYTE_W-1:0] lead_ff, lead_in;
   logic [BYTE_W-1:0] offset_ff, offset_in;
   logic [CNT_W-1:0]  run_count_ff, run_count_in;
   logic              in_run_ff, in_run_in;
   logic              after_lead_ff, after_lead_in;
   logic              dropped_ff, dropped_in;
   logic              last_space_ff, last_space_in;
   logic [CNT_W-1:0]  rd_todo_ff, rd_todo_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              tail_ff, tail_in;
   logic              code_ff, code_in;
   logic              end_ff, end_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // Working signals
   logic              out_free;
   logic              accept;
   logic              has_room;
   logic [CNT_W-1:0]  push_count;
   logic              push_dropped;
   logic              push_space;
   logic              start_flush;
   logic [CNT_W-1:0]  fl_count;
   logic              fl_space;
   logic              fl_dropped;
   logic              fl_tail;
   logic [CNT_W-1:0]  fl_len;
   logic              consume;
   logic              issue;

   // Handshake of both channels.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Outcome of pushing the request byte into the run.
   assign has_room     = run_count_ff < CNT_W'(RUN_DEPTH);
   assign push_count   = run_count_ff + CNT_W'(has_room);
   assign push_dropped = dropped_ff || !has_room;
   assign push_space   = has_room ? (req_byte == SPACE_CHAR) : last_space_ff;

   // Drain side of the run memory.
   assign consume = (state_ff == ST_DRAIN) && rd_valid_ff && out_free;
   assign issue   = (state_ff == ST_DRAIN) && (rd_todo_ff != '0) && (!rd_valid_ff || consume);

   // Next state and outputs.
   always_comb begin
      state_in      = state_ff;
      lead_in       = lead_ff;
      offset_in     = offset_ff;
      run_count_in  = run_count_ff;
      in_run_in     = in_run_ff;
      after_lead_in = after_lead_ff;
      dropped_in    = dropped_ff;
      last_space_in = last_space_ff;
      rd_todo_in    = rd_todo_ff;
      rd_addr_in    = rd_addr_ff;
      tail_in       = tail_ff;
      code_in       = code_ff;
      end_in        = end_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      mem_ctl       = '0;
      start_flush   = 1'b0;
      fl_count      = run_count_ff;
      fl_space      = last_space_ff;
      fl_dropped    = dropped_ff;
      rd_valid_in   = issue || (rd_valid_ff && !consume);

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            REG_LEAD_BYTE:     lead_in   = csr_wdata;
            REG_LETTER_OFFSET: offset_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (after_lead_ff) begin
                  // Second byte of a letter.
                  after_lead_in = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = req_byte + offset_ff;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = req_end;
                  rsp_ovf_in    = 1'b0;
               end else if (req_byte == lead_ff) begin
                  // Lead byte closes any open run.
                  if (in_run_ff && (run_count_ff != '0)) begin
                     start_flush   = 1'b1;
                     code_in       = req_end;
                     after_lead_in = !req_end;
                  end else if (req_end) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = offset_ff;
                     rsp_last_in  = 1'b1;
                     rsp_done_in  = 1'b1;
                     rsp_ovf_in   = 1'b0;
                  end else begin
                     after_lead_in = 1'b1;
                  end
               end else if (in_run_ff || (req_byte != SPACE_CHAR)) begin
                  // Run byte goes onto the stack, or is dropped when full.
                  mem_ctl.wr_en = has_room;
                  run_count_in  = push_count;
                  dropped_in    = push_dropped;
                  last_space_in = push_space;
                  in_run_in     = 1'b1;
                  if (req_end) begin
                     start_flush = 1'b1;
                     fl_count    = push_count;
                     fl_space    = push_space;
                     fl_dropped  = push_dropped;
                     code_in     = 1'b0;
                  end
               end else begin
                  // Space outside a run passes through.
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_byte;
                  rsp_last_in  = 1'b1;
                  rsp_done_in  = req_end;
                  rsp_ovf_in   = 1'b0;
               end

               if (start_flush) begin
                  state_in      = ST_DRAIN;
                  ovf_in        = fl_dropped;
                  end_in        = req_end;
                  run_count_in  = '0;
                  in_run_in     = 1'b0;
                  dropped_in    = 1'b0;
                  last_space_in = 1'b0;
               end

               // End of text leaves a clean state for the next text.
               if (req_end) begin
                  after_lead_in = 1'b0;
                  in_run_in     = 1'b0;
                  run_count_in  = '0;
                  dropped_in    = 1'b0;
                  last_space_in = 1'b0;
               end
            end
         end

         ST_DRAIN: begin
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr_in    = rd_addr_ff - ADDR_W'(1);
               rd_todo_in    = rd_todo_ff - CNT_W'(1);
            end
            if (consume) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = mem_rd_data;
               rsp_last_in  = (rd_todo_ff == '0) && !tail_ff && !code_ff;
               rsp_done_in  = (rd_todo_ff == '0) && !tail_ff && !code_ff && end_ff;
               rsp_ovf_in   = ovf_ff;
               if (rd_todo_ff == '0) begin
                  if (tail_ff) begin
                     state_in = ST_TAIL;
                  end else if (code_ff) begin
                     state_in = ST_CODE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         ST_TAIL: begin
            // Trailing space of the run goes after the reversed bytes.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = SPACE_CHAR;
               rsp_last_in  = !code_ff;
               rsp_done_in  = !code_ff && end_ff;
               rsp_ovf_in   = ovf_ff;
               tail_in      = 1'b0;
               state_in     = code_ff ? ST_CODE : ST_IDLE;
            end
         end

         ST_CODE: begin
            // Lead byte at end of text yields the offset alone.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = offset_ff;
               rsp_last_in  = 1'b1;
               rsp_done_in  = 1'b1;
               rsp_ovf_in   = 1'b0;
               code_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Trailing space is held back only when the run has another byte.
      fl_tail = (fl_count >= CNT_W'(2)) && fl_space;
      fl_len  = fl_count - CNT_W'(fl_tail);
      if (start_flush) begin
         rd_todo_in = fl_len;
         rd_addr_in = ADDR_W'(fl_len - CNT_W'(1));
         tail_in    = fl_tail;
      end
   end

   // Memory addresses and data.
   assign mem_wr_addr = ADDR_W'(run_count_ff);
   assign mem_wr_data = req_byte;
   assign mem_rd_addr = rd_addr_ff;

   // Control state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lead_ff       <= LEAD_BYTE_RESET;
         offset_ff     <= LETTER_OFFSET_RESET;
         run_count_ff  <= '0;
         in_run_ff     <= 1'b0;
         after_lead_ff <= 1'b0;
         dropped_ff    <= 1'b0;
         last_space_ff <= 1'b0;
         rd_todo_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         tail_ff       <= 1'b0;
         code_ff       <= 1'b0;
         end_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lead_ff       <= lead_in;
         offset_ff     <= offset_in;
         run_count_ff  <= run_count_in;
         in_run_ff     <= in_run_in;
         after_lead_ff <= after_lead_in;
         dropped_ff    <= dropped_in;
         last_space_ff <= last_space_in;
         rd_todo_ff    <= rd_todo_in;
         rd_valid_ff   <= rd_valid_in;
         tail_ff       <= tail_in;
         code_ff       <= code_in;
         end_ff        <= end_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte       = rsp_byte_ff;
   assign rsp_burst_last = rsp_last_ff;
   assign rsp_text_done  = rsp_done_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // Assertions.
   `RTRR_ASSERT_ALWAYS(a_count_bound, clock, reset, run_count_ff <= CNT_W'(RUN_DEPTH))
   `RTRR_ASSERT_IMPLY(a_lead_no_run, clock, reset, after_lead_ff, !in_run_ff && run_count_ff == '0)
   `RTRR_ASSERT_IMPLY(a_read_in_drain, clock, reset, rd_valid_ff || rd_todo_ff != '0, state_ff == ST_DRAIN)
   `RTRR_ASSERT_IMPLY(a_idle_run_clear, clock, reset, !in_run_ff, run_count_ff == '0 && !dropped_ff)

endmodule

// ===== rtl/core/rtl_text_run_reorder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text run reorder unit
// Turns a UTF-8 byte stream into LCD codes in right-to-left write order.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_*    in         tdata = in_byte[7:0]; tlast = text_end
//  rsp_*    out        tdata = out_byte[7:0]; tlast = text_done;
//                      tuser[0] = burst_last, tuser[1] = run_overflow
//  csr_*    in         index 0 = lead_byte, index 1 = letter_offset
//
// A request that yields no result or one result is handled in the idle state.
// A request that closes a run of stored bytes drains them in reverse, then sends
// a moved trailing space and a final letter offset code where needed; the single
// read port of the run memory sets the one byte per cycle drain unless stalled.
// Reset is synchronous and active high; the run memory is not cleared.
// A stalled result channel holds the result register and stops the drain.
// ----------------------------------------------------------------------------
module rtl_text_run_reorder_unit
   import rtrr_pkg::*;
#(
   parameter int RUN_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata,
   // Requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   input  logic                  req_tlast,
   // Results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser    // [0] burst_last, [1] run_overflow
);

   localparam int ADDR_W = $clog2(RUN_DEPTH);
   localparam int CNT_W  = $clog2(RUN_DEPTH + 1);

   rtrr_mem_ctl_type  mem_ctl;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;
   logic              rsp_burst_last;
   logic              rsp_overflow;

   // Sequencer and result register.
   rtrr_ctrl #(
      .RUN_DEPTH (RUN_DEPTH),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_byte       (req_tdata),
      .req_end        (req_tlast),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_byte       (rsp_tdata),
      .rsp_burst_last (rsp_burst_last),
      .rsp_text_done  (rsp_tlast),
      .rsp_overflow   (rsp_overflow),
      .mem_ctl        (mem_ctl),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // Run store.
   rtrr_run_mem #(
      .DEPTH  (RUN_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_run_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result flags.
   assign rsp_tuser = {rsp_overflow, rsp_burst_last};

endmodule
